/* rtl/pwmc_pkg.sv */
package pwmc_pkg;

  localparam int AVG_PERIODS = 30;
  localparam int COUNT_BITS  = 24;

  localparam int PRESC_W    = 16;
  localparam int FIELD_W    = 24;
  localparam int ANGLE_W    = 16;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 2 * FIELD_W + ANGLE_W;

  localparam int SCALE_DIV  = 4115;
  localparam int SCALE_W    = 13;
  localparam int ANGLE_MAX  = 46079;
  // 46080 = 45 << 10
  localparam int TURN_MUL   = 45;
  localparam int TURN_SHIFT = 10;

  localparam int DONE_W = $clog2(AVG_PERIODS + 1);
  localparam int SUM_W  = COUNT_BITS + DONE_W;
  localparam int PROD_W = COUNT_BITS + SCALE_W;
  localparam int REM_W  = PROD_W + ANGLE_W;
  localparam int ANG_QW = ANGLE_W;
  localparam int DSH_W  = PROD_W + ANG_QW - 1;
  localparam int QCNT_W = $clog2(ANG_QW + 1);

  // ceil(2^AVG_RSH / AVG_PERIODS); exact floor quotient for any period sum
  localparam int AVG_RSH = SUM_W + $clog2(AVG_PERIODS);
  localparam int AVG_PW  = AVG_RSH + COUNT_BITS;
  localparam longint unsigned AVG_RECIP =
    ((64'd1 << AVG_RSH) + 64'(AVG_PERIODS) - 64'd1) / 64'(AVG_PERIODS);

  typedef struct packed {
    logic avg_go;
    logic high_go;
  } cap_sts_t;

  typedef struct packed {
    logic avg_ld;
    logic div_step;
    logic avg_save;
    logic ang_mul;
    logic ang_chk;
    logic ang_scl;
    logic out_ld;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic ang_direct;
    logic out_free;
  } arith_sts_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_AVG_MUL,
    S_ANG_CHK,
    S_ANG_SCL,
    S_ANG_DIV,
    S_ANG_OUT
  } state_t;

endpackage

/* rtl/pwmc_capture.sv */
module pwmc_capture import pwmc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [PRESC_W-1:0]    cfg_wdata,
  input  logic                  item_fire,
  input  logic                  pin,
  output cap_sts_t              sts,
  output logic [SUM_W-1:0]      sum,
  output logic [COUNT_BITS-1:0] high
);

  logic [PRESC_W-1:0]    prescale_r;
  logic [PRESC_W-1:0]    presc_cnt_r, presc_cnt_nxt;
  logic [COUNT_BITS-1:0] tick_cnt_r, tick_cnt_nxt;
  logic                  meas_r, meas_nxt;
  logic                  phase_r, phase_nxt;
  logic [DONE_W-1:0]     done_r, done_nxt;
  logic [SUM_W-1:0]      sum_r, sum_nxt;
  logic                  prev_r;
  logic [COUNT_BITS-1:0] high_r, high_nxt;
  cap_sts_t              sts_r, sts_nxt;

  logic              tick, rising, falling, started;
  logic [DONE_W-1:0] done_inc;

  always_comb begin
    tick          = presc_cnt_r >= prescale_r;
    presc_cnt_nxt = tick ? '0 : presc_cnt_r + 1'b1;
    rising        = pin && !prev_r;
    falling       = !pin && prev_r;
    done_inc      = done_r + 1'b1;
    started       = 1'b0;
    tick_cnt_nxt  = tick_cnt_r;
    meas_nxt      = meas_r;
    phase_nxt     = phase_r;
    done_nxt      = done_r;
    sum_nxt       = sum_r;
    high_nxt      = high_r;
    sts_nxt       = '0;
    if (!phase_r) begin
      if (rising) begin
        if (!meas_r) begin
          meas_nxt     = 1'b1;
          tick_cnt_nxt = '0;
          started      = 1'b1;
        end else begin
          sum_nxt  = sum_r + SUM_W'(tick_cnt_r);
          done_nxt = done_inc;
          meas_nxt = 1'b0;
          if (done_inc >= DONE_W'(AVG_PERIODS)) begin
            phase_nxt      = 1'b1;
            sts_nxt.avg_go = 1'b1;
          end
        end
      end
    end else begin
      if (rising && !meas_r) begin
        meas_nxt     = 1'b1;
        tick_cnt_nxt = '0;
        started      = 1'b1;
      end else if (falling && meas_r) begin
        high_nxt        = tick_cnt_r;
        meas_nxt        = 1'b0;
        sts_nxt.high_go = 1'b1;
      end
    end
    if (meas_nxt && !started && tick && (tick_cnt_r != '1)) begin
      tick_cnt_nxt = tick_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prescale_r  <= '0;
      presc_cnt_r <= '0;
      tick_cnt_r  <= '0;
      meas_r      <= 1'b0;
      phase_r     <= 1'b0;
      done_r      <= '0;
      sum_r       <= '0;
      prev_r      <= 1'b0;
      sts_r       <= '0;
    end else begin
      if (cfg_we) begin
        prescale_r <= cfg_wdata;
      end
      sts_r <= item_fire ? sts_nxt : '0;
      if (item_fire) begin
        presc_cnt_r <= presc_cnt_nxt;
        tick_cnt_r  <= tick_cnt_nxt;
        meas_r      <= meas_nxt;
        phase_r     <= phase_nxt;
        done_r      <= done_nxt;
        sum_r       <= sum_nxt;
        prev_r      <= pin;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_fire) begin
      high_r <= high_nxt;
    end
  end

  assign sts  = sts_r;
  assign sum  = sum_r;
  assign high = high_r;

endmodule

/* rtl/pwmc_arith.sv */
module pwmc_arith import pwmc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  input  logic [SUM_W-1:0]      sum,
  input  logic [COUNT_BITS-1:0] high,
  input  logic                  out_tready,
  output arith_sts_t            sts,
  output logic                  out_tvalid,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  logic [AVG_PW-1:0]     avg_prod_r;
  logic [COUNT_BITS-1:0] period_avg_r;
  logic [PROD_W-1:0]     p4115_r, p4116_r, h4_r, diff_r;
  logic                  dir_r;
  logic [ANGLE_W-1:0]    angle_r;
  logic [REM_W-1:0]      rem_r;
  logic [DSH_W-1:0]      dsh_r;
  logic [ANG_QW-1:0]     q_r;
  logic [QCNT_W-1:0]     cnt_r;
  logic                  out_valid_r;
  logic [FIELD_W-1:0]    out_high_r, out_period_r;
  logic [ANGLE_W-1:0]    out_angle_r;

  logic [COUNT_BITS-1:0] avg_q;
  logic [PROD_W-1:0]     p_ext;
  logic                  ang_zero, ang_sat, div_ge;
  logic [REM_W-1:0]      dsh_ext, scl_prod;

  always_comb begin
    avg_q    = avg_prod_r[AVG_PW-1 -: COUNT_BITS];
    p_ext    = PROD_W'(period_avg_r);
    ang_zero = h4_r <= p_ext;
    ang_sat  = h4_r >= p4116_r;
    dsh_ext  = REM_W'(dsh_r);
    div_ge   = rem_r >= dsh_ext;
    scl_prod = REM_W'(diff_r) * REM_W'(TURN_MUL);
  end

  always_ff @(posedge clk) begin
    if (cmd.avg_ld) begin
      avg_prod_r <= AVG_PW'(sum) * AVG_PW'(AVG_RECIP);
    end
    if (cmd.ang_mul) begin
      h4_r <= PROD_W'(high) * PROD_W'(SCALE_DIV);
    end
    if (cmd.avg_save) begin
      period_avg_r <= avg_q;
      p4115_r      <= PROD_W'(avg_q) * PROD_W'(SCALE_DIV);
      p4116_r      <= PROD_W'(avg_q) * PROD_W'(SCALE_DIV + 1);
    end
    if (cmd.ang_chk) begin
      diff_r  <= h4_r - p_ext;
      dir_r   <= ang_zero || ang_sat;
      angle_r <= ang_zero ? '0 : ANGLE_W'(ANGLE_MAX);
    end
    if (cmd.ang_scl) begin
      rem_r <= scl_prod << TURN_SHIFT;
      dsh_r <= DSH_W'(p4115_r) << (ANG_QW - 1);
      q_r   <= '0;
    end else if (cmd.div_step && (cnt_r != '0)) begin
      if (div_ge) begin
        rem_r <= rem_r - dsh_ext;
      end
      q_r   <= {q_r[ANG_QW-2:0], div_ge};
      dsh_r <= dsh_r >> 1;
    end
    if (cmd.out_ld) begin
      out_high_r   <= FIELD_W'(high);
      out_period_r <= FIELD_W'(period_avg_r);
      out_angle_r  <= dir_r ? angle_r : q_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.ang_scl) begin
        cnt_r <= QCNT_W'(ANG_QW);
      end else if (cmd.div_step && (cnt_r != '0)) begin
        cnt_r <= cnt_r - 1'b1;
      end
      if (cmd.out_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.div_done   = cnt_r == '0;
  assign sts.ang_direct = ang_zero || ang_sat;
  assign sts.out_free   = !out_valid_r || out_tready;
  assign out_tvalid     = out_valid_r;
  assign out_tdata      = {out_angle_r, out_period_r, out_high_r};

endmodule

/* rtl/pwmc_ctrl.sv */
module pwmc_ctrl import pwmc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cap_sts_t   cap_sts,
  input  arith_sts_t ar_sts,
  output cmd_t       cmd,
  output logic       in_ready
);

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cap_sts.avg_go) begin
          state_nxt = S_AVG_MUL;
        end else if (cap_sts.high_go) begin
          state_nxt = S_ANG_CHK;
        end
      end
      S_AVG_MUL: state_nxt = S_IDLE;
      S_ANG_CHK: state_nxt = ar_sts.ang_direct ? S_ANG_OUT : S_ANG_SCL;
      S_ANG_SCL: state_nxt = S_ANG_DIV;
      S_ANG_DIV: begin
        if (ar_sts.div_done) begin
          state_nxt = S_ANG_OUT;
        end
      end
      S_ANG_OUT: begin
        if (ar_sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        cmd.avg_ld  = cap_sts.avg_go;
        cmd.ang_mul = cap_sts.high_go;
        in_ready    = !cap_sts.avg_go && !cap_sts.high_go;
      end
      S_AVG_MUL: cmd.avg_save = 1'b1;
      S_ANG_CHK: cmd.ang_chk  = 1'b1;
      S_ANG_SCL: cmd.ang_scl  = 1'b1;
      S_ANG_DIV: cmd.div_step = 1'b1;
      S_ANG_OUT: cmd.out_ld   = ar_sts.out_free;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/pwm_period_and_duty_capture.sv */
// Input: one pin word per cycle while idle; a word that ends the 30th period stalls
// in_tready for the reciprocal multiply of the period sum, then scaling. A falling edge in
// the high phase stalls input for the angle check (saturated/zero angle) or the 16-step
// angle quotient; the result word is registered and shows on out_tdata as the stall ends.
// A result word held by out_tready low lengthens the stall of the next falling edge.
// Reset (rst_n low, synchronous) clears prescaler, counters, phase and output valid.
module pwm_period_and_duty_capture import pwmc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [PRESC_W-1:0]    cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [0] pin_level, [7:1] zero
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // [23:0] high_ticks, [47:24] period_avg_ticks,
                                            // [63:48] angle
);

  cap_sts_t              cap_sts;
  arith_sts_t            ar_sts;
  cmd_t                  cmd;
  logic [SUM_W-1:0]      sum;
  logic [COUNT_BITS-1:0] high;
  logic                  item_fire;

  assign item_fire = in_tvalid && in_tready;

  pwmc_capture u_cap (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .item_fire (item_fire),
    .pin       (in_tdata[0]),
    .sts       (cap_sts),
    .sum       (sum),
    .high      (high)
  );

  pwmc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cap_sts  (cap_sts),
    .ar_sts   (ar_sts),
    .cmd      (cmd),
    .in_ready (in_tready)
  );

  pwmc_arith u_arith (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sum        (sum),
    .high       (high),
    .out_tready (out_tready),
    .sts        (ar_sts),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

  a_evt_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cap_sts.avg_go && cap_sts.high_go))
    else $error("period and high capture in same cycle");

  a_evt_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (cap_sts.avg_go || cap_sts.high_go) |-> !in_tready)
    else $error("input taken while capture pending");

  a_high_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cap_sts.high_go |=> !in_tready && !cap_sts.high_go)
    else $error("input taken during angle computation");

  a_angle_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_DATA_W-1 -: ANGLE_W] <= ANGLE_W'(ANGLE_MAX))
    else $error("angle out of range");

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import pwmc_pkg::*;

  localparam int STUCK_LIMIT = 4000;
  localparam int QUIET_CYCLES = 40;
  localparam int LONG_HOLD = 400;

  typedef struct {
    logic level;
    bit   drain;
  } pin_item_t;

  typedef struct {
    logic [FIELD_W-1:0] high;
    logic [FIELD_W-1:0] period;
    logic [ANGLE_W-1:0] angle;
  } capture_t;

  typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [PRESC_W-1:0]    cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  pin_item_t pin_words[$];
  capture_t  due_captures[$];
  int        errors = 0;

  // predicted block state
  logic [PRESC_W-1:0] presc_cfg = '0;
  logic [PRESC_W-1:0] presc_cnt = '0;
  logic [FIELD_W-1:0] tick_cnt = '0;
  logic               measuring = 1'b0;
  logic               high_phase = 1'b0;
  logic [DONE_W-1:0]  periods_done = '0;
  logic [SUM_W-1:0]   period_sum = '0;
  logic [FIELD_W-1:0] period_avg = '0;
  logic               prev_pin = 1'b0;

  int burst_left = 0;
  int gap_left = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_cnt = 0;
  logic [5:0] rx_phase = '0;
  rx_mode_t rx_mode = RX_OPEN;
  int stuck_cycles = 0;

  pwm_period_and_duty_capture dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [ANGLE_W-1:0] calc_angle(logic [FIELD_W-1:0] hi,
                                                    logic [FIELD_W-1:0] per);
    longint unsigned h4;
    longint unsigned p64;
    longint unsigned q;
    if (per == '0) return (hi != '0) ? ANGLE_W'(ANGLE_MAX) : '0;
    p64 = 64'(per);
    h4 = 64'(hi);
    h4 = h4 * SCALE_DIV;
    if (h4 <= p64) return '0;
    q = (longint'(ANGLE_MAX + 1) * (h4 - p64)) / (longint'(SCALE_DIV) * p64);
    return (q > ANGLE_MAX) ? ANGLE_W'(ANGLE_MAX) : ANGLE_W'(q);
  endfunction

  function automatic void advance_capture(logic level);
    logic     rising;
    logic     falling;
    logic     tick;
    logic     started;
    capture_t c;
    rising = level & ~prev_pin;
    falling = ~level & prev_pin;
    started = 1'b0;
    tick = presc_cnt >= presc_cfg;
    presc_cnt = tick ? '0 : presc_cnt + 1'b1;
    if (!high_phase) begin
      if (rising) begin
        if (!measuring) begin
          measuring = 1'b1;
          tick_cnt = '0;
          started = 1'b1;
        end else begin
          period_sum = period_sum + SUM_W'(tick_cnt);
          periods_done = periods_done + 1'b1;
          measuring = 1'b0;
          if (periods_done >= AVG_PERIODS) begin
            period_avg = FIELD_W'(period_sum / AVG_PERIODS);
            high_phase = 1'b1;
          end
        end
      end
    end else if (rising && !measuring) begin
      measuring = 1'b1;
      tick_cnt = '0;
      started = 1'b1;
    end else if (falling && measuring) begin
      c.high = tick_cnt;
      c.period = period_avg;
      c.angle = calc_angle(tick_cnt, period_avg);
      due_captures.push_back(c);
      measuring = 1'b0;
    end
    if (measuring && !started && tick && tick_cnt != '1) tick_cnt = tick_cnt + 1'b1;
    prev_pin = level;
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= 100) $display("%0t mismatch: %s", $time, msg);
  endtask

  task automatic push_word(input logic level, input bit drain = 1'b0);
    pin_item_t it;
    it.level = level;
    it.drain = drain;
    pin_words.push_back(it);
  endtask

  task automatic push_pulse(input int hi, input int lo, input bit drain = 1'b0);
    for (int i = 0; i < hi; i++) push_word(1'b1, drain && i == 0);
    for (int i = 0; i < lo; i++) push_word(1'b0);
  endtask

  // mostly clean pulses, some bursts of random pin noise
  task automatic push_pulses(input int n, input int hi_max, input int lo_max);
    int n_noise;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        n_noise = $urandom_range(1, 6);
        for (int j = 0; j < n_noise; j++) push_word(1'($urandom_range(0, 1)));
        push_word(1'b0);
      end else begin
        push_pulse($urandom_range(1, hi_max), $urandom_range(1, lo_max));
      end
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (pin_words.size() > 0 || in_tvalid || due_captures.size() > 0) @(negedge clk);
  endtask

  task automatic set_prescale(input logic [PRESC_W-1:0] value);
    wait_drained();
    repeat (QUIET_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    presc_cfg = value;
    @(negedge clk);
  endtask

  always @(posedge clk) begin : tx_side
    pin_item_t it;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) advance_capture(in_tdata[0]);
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (pin_words.size() > 0 &&
                     !(pin_words[0].drain && due_captures.size() > 0)) begin
          it = pin_words.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {{(IN_DATA_W-1){1'b0}}, it.level};
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : rx_side
    capture_t c;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (due_captures.size() == 0) begin
          report_mismatch($sformatf("unexpected result word %h", out_tdata));
        end else begin
          c = due_captures.pop_front();
          if (out_tdata[FIELD_W-1:0] !== c.high)
            report_mismatch($sformatf("high_ticks %0d, want %0d",
                                      out_tdata[FIELD_W-1:0], c.high));
          if (out_tdata[2*FIELD_W-1:FIELD_W] !== c.period)
            report_mismatch($sformatf("period_avg_ticks %0d, want %0d",
                                      out_tdata[2*FIELD_W-1:FIELD_W], c.period));
          if (out_tdata[OUT_DATA_W-1:2*FIELD_W] !== c.angle)
            report_mismatch($sformatf("angle %0d, want %0d",
                                      out_tdata[OUT_DATA_W-1:2*FIELD_W], c.angle));
        end
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_tready <= 1'b0;
      end else if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_cnt = LONG_HOLD;
        out_tready <= 1'b0;
      end else begin
        rx_phase = rx_phase + 1'b1;
        if (rx_phase == '0) rx_mode = rx_mode_t'($urandom_range(0, 3));
        case (rx_mode)
          RX_OPEN:     out_tready <= 1'b1;
          RX_COIN:     out_tready <= 1'($urandom_range(0, 1));
          RX_SPARSE:   out_tready <= ($urandom_range(0, 3) == 0);
          RX_PERIODIC: out_tready <= rx_phase[2];
          default:     out_tready <= 1'b1;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  initial begin
    int k;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // period averaging at full tick rate
    set_prescale('0);
    push_word(1'b0); push_word(1'b0);
    push_pulse(2, 2);
    push_pulse(1, 1);
    push_pulse(3, 1);
    push_pulses(64, 6, 6);

    // high-time capture: zero high, saturated angle, near full period, then a drain
    set_prescale('0);
    push_pulse(1, 3);
    push_pulse(2, 3);
    push_pulse(60, 5);
    push_pulse(9, 4, 1'b1);
    push_pulses(9, 24, 8);
    @(negedge clk);
    while (pin_words.size() > 120) @(negedge clk);
    hold_req++;

    set_prescale('1);
    push_pulses(6, 10, 5);

    k = $urandom_range(1, 6);
    set_prescale(PRESC_W'(k));
    push_pulses(3, 12 * (k + 1), 8);

    set_prescale(PRESC_W'($urandom_range(0, 65535)));
    push_pulses(5, 20, 6);

    wait_drained();
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
